// ===== hw/rtl/bcd_pkg.sv =====
// Shared types, register indexes and palette arithmetic for the BC1/BC3 block decoder.
// No dependencies; every other file in hw/rtl except bcd_if imports this package.

package bcd_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int SIDE_W     = 17;

    localparam logic [1:0] REG_BLOCK_MODE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // One classified block as it travels from the front end to the texel emitter.
    typedef struct packed {
        logic [3:0][7:0] red;
        logic [3:0][7:0] green;
        logic [3:0][7:0] blue;
        logic [7:0][7:0] alpha;
        logic [31:0]     cidx;
        logic [47:0]     aidx;
        logic            bc3;
        logic            three_color;
        logic [15:0]     mask;
        logic [11:0]     block_x;
        logic [11:0]     block_y;
    } t_block;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // Reciprocal multiplications, exact over the operand ranges that occur here.
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [20:0] p;
        p = 21'(v) * 21'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'd3277;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'd2341;
        return p[21:14];
    endfunction

endpackage

// ===== hw/rtl/bcd_if.sv =====
// Valid/ready channel interfaces for compressed blocks in and decoded texels out.
// Depends on nothing but plain logic types.

interface bcd_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] block_x;
    logic [11:0] block_y;
    logic [63:0] color_word;
    logic [63:0] alpha_word;

    modport source (output valid, block_x, block_y, color_word, alpha_word, input ready);
    modport sink (input valid, block_x, block_y, color_word, alpha_word, output ready);
endinterface

interface bcd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  opacity;
    logic [13:0] texel_x;
    logic [13:0] texel_y;
    logic        last_texel;

    modport source (output valid, red, green, blue, opacity, texel_x, texel_y, last_texel,
                    input ready);
    modport sink (input valid, red, green, blue, opacity, texel_x, texel_y, last_texel,
                  output ready);
endinterface

// ===== hw/rtl/bcd_front.sv =====
// Front end: takes block transactions, builds color and alpha palettes and the crop mask.
// Depends on bcd_pkg and bcd_in_if; feeds bcd_queue.

module bcd_front import bcd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcd_in_if.sink            i_blk,
    input  logic              i_block_mode,
    input  logic [SIDE_W-1:0] i_width_eff,
    input  logic [SIDE_W-1:0] i_height_eff,
    input  logic              i_q_full,
    output logic              o_push,
    output t_block            o_entry
);

    logic        r_valid;
    logic [11:0] r_bx;
    logic [11:0] r_by;
    logic [63:0] r_cw;
    logic [63:0] r_aw;

    logic [15:0] e0, e1;
    logic [7:0]  c0 [3];
    logic [7:0]  c1 [3];
    logic        four;
    logic [7:0]  a0, a1;
    logic [10:0] ea0, ea1;
    logic [3:0]  col_ok, row_ok;
    logic        drop;
    logic        advance;

    always_comb begin
        e0 = r_cw[15:0];
        e1 = r_cw[31:16];
        c0[0] = expand5(e0[15:11]);
        c0[1] = expand6(e0[10:5]);
        c0[2] = expand5(e0[4:0]);
        c1[0] = expand5(e1[15:11]);
        c1[1] = expand6(e1[10:5]);
        c1[2] = expand5(e1[4:0]);
        four  = i_block_mode || (e0 > e1);

        o_entry = '0;
        for (int ch = 0; ch < 3; ch++) begin
            logic [7:0] p2, p3;
            if (four) begin
                p2 = div3({1'b0, c0[ch], 1'b0} + {2'b0, c1[ch]});
                p3 = div3({2'b0, c0[ch]} + {1'b0, c1[ch], 1'b0});
            end else begin
                p2 = 8'(({1'b0, c0[ch]} + {1'b0, c1[ch]}) >> 1);
                p3 = 8'd0;
            end
            case (ch)
                0: o_entry.red   = {p3, p2, c1[ch], c0[ch]};
                1: o_entry.green = {p3, p2, c1[ch], c0[ch]};
                default: o_entry.blue = {p3, p2, c1[ch], c0[ch]};
            endcase
        end

        a0  = r_aw[7:0];
        a1  = r_aw[15:8];
        ea0 = {3'b0, a0};
        ea1 = {3'b0, a1};
        o_entry.alpha[0] = a0;
        o_entry.alpha[1] = a1;
        if (a0 > a1) begin
            o_entry.alpha[2] = div7(ea0 * 11'd6 + ea1);
            o_entry.alpha[3] = div7(ea0 * 11'd5 + ea1 * 11'd2);
            o_entry.alpha[4] = div7(ea0 * 11'd4 + ea1 * 11'd3);
            o_entry.alpha[5] = div7(ea0 * 11'd3 + ea1 * 11'd4);
            o_entry.alpha[6] = div7(ea0 * 11'd2 + ea1 * 11'd5);
            o_entry.alpha[7] = div7(ea0 + ea1 * 11'd6);
        end else begin
            o_entry.alpha[2] = div5(ea0 * 11'd4 + ea1);
            o_entry.alpha[3] = div5(ea0 * 11'd3 + ea1 * 11'd2);
            o_entry.alpha[4] = div5(ea0 * 11'd2 + ea1 * 11'd3);
            o_entry.alpha[5] = div5(ea0 + ea1 * 11'd4);
            o_entry.alpha[6] = 8'd0;
            o_entry.alpha[7] = 8'd255;
        end

        // Texel coordinate is the block position with the in-block offset appended.
        for (int i = 0; i < 4; i++) begin
            col_ok[i] = {3'b0, r_bx, 2'(i)} < i_width_eff;
            row_ok[i] = {3'b0, r_by, 2'(i)} < i_height_eff;
        end
        for (int t = 0; t < 16; t++) begin
            o_entry.mask[t] = row_ok[t / 4] && col_ok[t % 4];
        end

        o_entry.cidx        = r_cw[63:32];
        o_entry.aidx        = r_aw[63:16];
        o_entry.bc3         = i_block_mode;
        o_entry.three_color = !four;
        o_entry.block_x     = r_bx;
        o_entry.block_y     = r_by;
    end

    // A block with no texel inside the image is retired here without a queue slot.
    assign drop        = (o_entry.mask == 16'd0);
    assign o_push      = r_valid && !drop && !i_q_full;
    assign advance     = !r_valid || drop || !i_q_full;
    assign i_blk.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_blk.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_blk.valid) begin
            r_bx <= i_blk.block_x;
            r_by <= i_blk.block_y;
            r_cw <= i_blk.color_word;
            r_aw <= i_blk.alpha_word;
        end
    end

endmodule

// ===== hw/rtl/bcd_queue.sv =====
// Two-entry queue of classified blocks between the front end and the texel emitter.
// Depends on bcd_pkg for the entry type.

module bcd_queue import bcd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_block i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_block o_data
);

    t_block     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("block pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("block popped from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue occupancy out of range");

endmodule

// ===== hw/rtl/bcd_back.sv =====
// Texel emitter: walks the in-image texels of the head block, one per cycle unless
// stalled, into an output register. Depends on bcd_pkg and bcd_out_if; reads from bcd_queue.

module bcd_back import bcd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_block i_q_data,
    output logic   o_pop,
    bcd_out_if.source o_tex
);

    logic [15:0] r_done;
    logic        r_out_valid;
    logic [7:0]  r_red, r_green, r_blue, r_opacity;
    logic [13:0] r_tx, r_ty;
    logic        r_last;

    logic [15:0] remain;
    logic [3:0]  sel;
    logic [15:0] sel_bit;
    logic        last;
    logic        load;
    logic [1:0]  ci;
    logic [2:0]  ai;
    logic [7:0]  n_opacity;
    logic [15:0] n_done;

    always_comb begin
        remain = i_q_data.mask & ~r_done;
        sel = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (remain[i]) begin
                sel = 4'(i);
            end
        end
        sel_bit = 16'd1 << sel;
        last    = (remain == sel_bit);
        load    = i_q_valid && (!r_out_valid || o_tex.ready);
        o_pop   = load && last;

        ci = i_q_data.cidx[{sel, 1'b0} +: 2];
        ai = i_q_data.aidx[6'(sel) * 6'd3 +: 3];
        if (i_q_data.bc3) begin
            n_opacity = i_q_data.alpha[ai];
        end else if (i_q_data.three_color && (ci == 2'd3)) begin
            n_opacity = 8'd0;
        end else begin
            n_opacity = 8'd255;
        end

        if (o_pop) begin
            n_done = 16'd0;
        end else if (load) begin
            n_done = r_done | sel_bit;
        end else begin
            n_done = r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_tex.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_red     <= i_q_data.red[ci];
            r_green   <= i_q_data.green[ci];
            r_blue    <= i_q_data.blue[ci];
            r_opacity <= n_opacity;
            r_tx      <= {i_q_data.block_x, sel[1:0]};
            r_ty      <= {i_q_data.block_y, sel[3:2]};
            r_last    <= last;
        end
    end

    assign o_tex.valid      = r_out_valid;
    assign o_tex.red        = r_red;
    assign o_tex.green      = r_green;
    assign o_tex.blue       = r_blue;
    assign o_tex.opacity    = r_opacity;
    assign o_tex.texel_x    = r_tx;
    assign o_tex.texel_y    = r_ty;
    assign o_tex.last_texel = r_last;

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> ((r_done & ~i_q_data.mask) == 16'd0))
        else $error("emitted-texel record covers a texel outside the block mask");

    a_done_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_done == 16'd0))
        else $error("emitted-texel record not cleared between blocks");

    a_head_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (remain != 16'd0))
        else $error("queued block has no texel left to emit");

endmodule

// ===== hw/rtl/bc1_bc3_block_decoder.sv =====
// BC1/BC3 block decoder top level: APB registers, front end, block queue, texel emitter.
// The first texel of a block passes the front-end input register, the block queue and the
// texel output register. Throughput: one texel per cycle while the receiver is ready, set by the
// single texel output register; a block wholly outside the image is dropped in the front end.
// Reset (synchronous, active low) empties the pipeline and queue and sets BC1 mode, 4x4 image.
// Depends on bcd_pkg, bcd_if, bcd_front, bcd_queue and bcd_back.

module bc1_bc3_block_decoder import bcd_pkg::*; #(
    parameter int MAX_IMAGE_SIDE = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bcd_in_if.sink                i_blk,
    bcd_out_if.source             o_tex,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready
);

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_IMAGE_SIDE);

    logic        r_block_mode;
    logic [14:0] r_image_width;
    logic [14:0] r_image_height;

    logic [1:0]        reg_idx;
    logic              wr_en;
    logic [SIDE_W-1:0] width_eff;
    logic [SIDE_W-1:0] height_eff;

    logic   q_push, q_full, q_valid, q_pop;
    t_block q_in, q_out;

    assign reg_idx  = i_paddr[3:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_mode   <= 1'b0;
            r_image_width  <= 15'd4;
            r_image_height <= 15'd4;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BLOCK_MODE:   r_block_mode   <= i_pwdata[0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_pwdata[14:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BLOCK_MODE:   o_prdata = {31'd0, r_block_mode};
            REG_IMAGE_WIDTH:  o_prdata = {17'd0, r_image_width};
            REG_IMAGE_HEIGHT: o_prdata = {17'd0, r_image_height};
            default:          o_prdata = 32'd0;
        endcase
    end

    // Oversized image sides are clamped to the largest supported side.
    assign width_eff  = (SIDE_W'(r_image_width) > SIDE_MAX) ? SIDE_MAX
                                                            : SIDE_W'(r_image_width);
    assign height_eff = (SIDE_W'(r_image_height) > SIDE_MAX) ? SIDE_MAX
                                                             : SIDE_W'(r_image_height);

    bcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blk        (i_blk),
        .i_block_mode (r_block_mode),
        .i_width_eff  (width_eff),
        .i_height_eff (height_eff),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_entry      (q_in)
    );

    bcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    bcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_pop     (q_pop),
        .o_tex     (o_tex)
    );

endmodule

// ===== tb/tb_bc1_bc3_block_decoder.sv =====
// Self-checking bench for the BC1/BC3 block decoder: directed blocks, then random phases.
// A scoreboard class decodes each accepted block and checks every emitted texel.
// Depends on bcd_pkg, bcd_if and the bc1_bc3_block_decoder top level.

typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  opacity;
    logic [13:0] texel_x;
    logic [13:0] texel_y;
    logic        last_texel;
} t_texel;

class texel_scoreboard;
    t_texel      texel_q[$];
    int unsigned errors;

    // Decodes one accepted block and queues the texels that fall inside the image.
    function void accept_block(bit bc3, int unsigned width, int unsigned height,
                               logic [11:0] bx, logic [11:0] by,
                               logic [63:0] cw, logic [63:0] aw);
        int unsigned pal[4][3];
        int unsigned pal_a[4];
        int unsigned alp[8];
        int unsigned a0, a1, x, y, t, ci, k, px, py;
        logic [15:0] e0, e1;
        t_texel      tx;
        t_texel      blk_q[$];

        e0 = cw[15:0];
        e1 = cw[31:16];
        pal[0][0] = {e0[15:11], e0[15:13]};
        pal[0][1] = {e0[10:5], e0[10:9]};
        pal[0][2] = {e0[4:0], e0[4:2]};
        pal[1][0] = {e1[15:11], e1[15:13]};
        pal[1][1] = {e1[10:5], e1[10:9]};
        pal[1][2] = {e1[4:0], e1[4:2]};
        pal_a[0] = 255;
        pal_a[1] = 255;
        pal_a[2] = 255;
        pal_a[3] = 255;
        if (bc3 || e0 > e1) begin
            for (k = 0; k < 3; k++) begin
                pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
                pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
            end
        end else begin
            // Three-color mode: the last entry is transparent black.
            for (k = 0; k < 3; k++) begin
                pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
                pal[3][k] = 0;
            end
            pal_a[3] = 0;
        end

        a0 = aw[7:0];
        a1 = aw[15:8];
        alp[0] = a0;
        alp[1] = a1;
        if (a0 > a1) begin
            for (k = 1; k <= 6; k++)
                alp[k + 1] = ((7 - k) * a0 + k * a1) / 7;
        end else begin
            for (k = 1; k <= 4; k++)
                alp[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            alp[6] = 0;
            alp[7] = 255;
        end

        for (py = 0; py < 4; py++) begin
            for (px = 0; px < 4; px++) begin
                y = int'(by) * 4 + py;
                x = int'(bx) * 4 + px;
                if (y < height && x < width) begin
                    t = py * 4 + px;
                    ci = cw[32 + 2 * t +: 2];
                    tx.red = 8'(pal[ci][0]);
                    tx.green = 8'(pal[ci][1]);
                    tx.blue = 8'(pal[ci][2]);
                    tx.opacity = 8'(bc3 ? alp[aw[16 + 3 * t +: 3]] : pal_a[ci]);
                    tx.texel_x = 14'(x);
                    tx.texel_y = 14'(y);
                    tx.last_texel = 1'b0;
                    blk_q.push_back(tx);
                end
            end
        end
        if (blk_q.size() != 0)
            blk_q[blk_q.size() - 1].last_texel = 1'b1;
        foreach (blk_q[i])
            texel_q.push_back(blk_q[i]);
    endfunction

    function void check_texel(t_texel got);
        t_texel want;

        if (texel_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected texel rgba %h %h %h %h at (%0d,%0d) last %b",
                         got.red, got.green, got.blue, got.opacity,
                         got.texel_x, got.texel_y, got.last_texel);
            return;
        end
        want = texel_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.opacity !== want.opacity || got.texel_x !== want.texel_x ||
            got.texel_y !== want.texel_y || got.last_texel !== want.last_texel) begin
            errors++;
            if (errors <= 10)
                $display("texel mismatch: expected rgba %h %h %h %h (%0d,%0d) last %b, %s",
                         want.red, want.green, want.blue, want.opacity,
                         want.texel_x, want.texel_y, want.last_texel,
                         $sformatf("got rgba %h %h %h %h (%0d,%0d) last %b",
                                   got.red, got.green, got.blue, got.opacity,
                                   got.texel_x, got.texel_y, got.last_texel));
        end
    endfunction
endclass

module tb_bc1_bc3_block_decoder;
    import bcd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SIDE      = 16384;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned PHASE_BLOCKS  = 34;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    bcd_in_if  blk_if();
    bcd_out_if tex_if();

    texel_scoreboard sb;

    // Register values as last written, used to predict each block.
    bit          shadow_bc3;
    int unsigned shadow_w;
    int unsigned shadow_h;

    bit          tx_gaps;
    bit          rx_stalls;
    bit          hold_req;
    int unsigned quiet_cycles;

    bc1_bc3_block_decoder #(.MAX_IMAGE_SIDE(MAX_SIDE)) uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_blk     (blk_if),
        .o_tex     (tex_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_side();
        case ($urandom_range(0, 9))
            6: return MAX_SIDE;
            7: return $urandom_range(MAX_SIDE + 1, 32767);
            8: return $urandom_range(1, MAX_SIDE);
            9: return $urandom_range(1, 4);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [63:0] rand_color();
        logic [15:0] e0;
        logic [15:0] e1;
        logic [31:0] idx;
        e0 = 16'($urandom);
        e1 = 16'($urandom);
        idx = $urandom;
        if ($urandom_range(0, 9) == 0)
            e1 = e0;
        return {idx, e1, e0};
    endfunction

    function automatic logic [63:0] rand_alpha();
        logic [31:0] hi;
        logic [15:0] mid;
        logic [7:0]  a0;
        logic [7:0]  a1;
        hi = $urandom;
        mid = 16'($urandom);
        a0 = 8'($urandom);
        a1 = 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            a1 = a0;
        return {hi, mid, a1, a0};
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BLOCK_MODE:   shadow_bc3 = val[0];
            REG_IMAGE_WIDTH:  shadow_w = val[14:0];
            REG_IMAGE_HEIGHT: shadow_h = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input bit bc3, input int unsigned w, input int unsigned h);
        logic [31:0] junk;
        junk = $urandom;
        reg_write(REG_BLOCK_MODE, {junk[31:1], bc3});
        junk = $urandom;
        reg_write(REG_IMAGE_WIDTH, {junk[31:15], w[14:0]});
        junk = $urandom;
        reg_write(REG_IMAGE_HEIGHT, {junk[31:15], h[14:0]});
    endtask

    task automatic send_block(input logic [11:0] bx, input logic [11:0] by,
                              input logic [63:0] cw, input logic [63:0] aw);
        int unsigned gap;
        gap = tx_gaps ? gap_len() : 0;
        if (gap != 0) begin
            blk_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blk_if.valid <= 1'b1;
        blk_if.block_x <= bx;
        blk_if.block_y <= by;
        blk_if.color_word <= cw;
        blk_if.alpha_word <= aw;
        do @(posedge clk); while (!blk_if.ready);
    endtask

    // Lets the decoder run dry, including blocks that emit nothing, before registers change.
    // The extra edge first lets the monitor record the last accepted block.
    task automatic settle();
        blk_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.texel_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Texel receiver with random back-pressure and one long hold-off on request.
    initial begin
        tex_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                tex_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                tex_if.ready <= 1'b0;
                repeat (1 + gap_len()) @(posedge clk);
            end else begin
                tex_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_texel      seen;
        bit          moved;
        int unsigned w_eff;
        int unsigned h_eff;
        moved = 1'b0;
        if (rst_n) begin
            if (blk_if.valid && blk_if.ready) begin
                w_eff = shadow_w > MAX_SIDE ? MAX_SIDE : shadow_w;
                h_eff = shadow_h > MAX_SIDE ? MAX_SIDE : shadow_h;
                sb.accept_block(shadow_bc3, w_eff, h_eff, blk_if.block_x, blk_if.block_y,
                                blk_if.color_word, blk_if.alpha_word);
                moved = 1'b1;
            end
            if (tex_if.valid && tex_if.ready) begin
                seen.red = tex_if.red;
                seen.green = tex_if.green;
                seen.blue = tex_if.blue;
                seen.opacity = tex_if.opacity;
                seen.texel_x = tex_if.texel_x;
                seen.texel_y = tex_if.texel_y;
                seen.last_texel = tex_if.last_texel;
                sb.check_texel(seen);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAIL bc1_bc3_block_decoder");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phase;
        int unsigned counted;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned bx;
        int unsigned by;

        sb = new();
        rst_n <= 1'b0;
        blk_if.valid <= 1'b0;
        blk_if.block_x <= '0;
        blk_if.block_y <= '0;
        blk_if.color_word <= '0;
        blk_if.alpha_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        shadow_bc3 = 1'b0;
        shadow_w = 4;
        shadow_h = 4;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        hold_req = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: BC1 with a 4x4 image. Cover both color modes and equal endpoints.
        send_block(0, 0, {32'hE4E4E4E4, 16'h1234, 16'hF81F}, '0);
        send_block(0, 0, {32'hE4E4E4E4, 16'hFFFF, 16'h0000}, '1);
        send_block(0, 0, {32'h1B1B1B1B, 16'h8410, 16'h8410}, '0);
        send_block(0, 0, '1, '1);
        send_block(0, 0, '0, '0);
        send_block(1, 0, rand_color(), rand_alpha());
        send_block(12'hFFF, 12'hFFF, rand_color(), rand_alpha());
        settle();

        // BC3 on the largest image: corner blocks and both alpha interpolation modes.
        set_config(1'b1, MAX_SIDE, MAX_SIDE);
        send_block(12'hFFF, 12'hFFF, {32'h4E4E4E4E, 16'hFFFF, 16'h0001},
                   {48'hFAC688FAC688, 8'h10, 8'hF0});
        send_block(0, 12'hFFF, rand_color(), {48'hFAC688FAC688, 8'hF0, 8'h10});
        send_block(12'hFFF, 0, rand_color(), {48'h053977053977, 8'h80, 8'h80});
        send_block(0, 0, '1, '1);
        send_block(0, 0, '0, '0);
        settle();

        // Edge blocks cropped by an image that is not a multiple of four.
        set_config(1'b0, 5, 7);
        send_block(0, 0, rand_color(), rand_alpha());
        send_block(1, 1, rand_color(), rand_alpha());
        send_block(0, 1, rand_color(), rand_alpha());
        send_block(1, 0, rand_color(), rand_alpha());
        send_block(2, 0, rand_color(), rand_alpha());
        send_block(0, 2, rand_color(), rand_alpha());
        settle();

        // Zero width, then zero height: nothing lies inside the image.
        set_config(1'b0, 0, 1);
        send_block(0, 0, rand_color(), rand_alpha());
        settle();
        set_config(1'b0, 1, 0);
        send_block(0, 0, rand_color(), rand_alpha());
        settle();

        // Oversized sides clamp to the maximum; then a one-texel image.
        set_config(1'b1, 32767, 32767);
        send_block(12'hFFF, 12'hFFF, rand_color(), rand_alpha());
        send_block(0, 0, rand_color(), rand_alpha());
        settle();
        set_config(1'b1, 1, 1);
        send_block(0, 0, rand_color(), rand_alpha());
        settle();

        for (phase = 0; phase < 8; phase++) begin
            set_config(1'($urandom_range(0, 1)), pick_side(), pick_side());
            w_eff = shadow_w > MAX_SIDE ? MAX_SIDE : shadow_w;
            h_eff = shadow_h > MAX_SIDE ? MAX_SIDE : shadow_h;
            tx_gaps = (phase != 2) && ($urandom_range(0, 3) != 0);
            rx_stalls = (phase != 2) && ($urandom_range(0, 3) != 0);
            // The first phase makes the receiver hold off long enough to back up the input.
            if (phase == 0)
                hold_req = 1'b1;
            counted = 0;
            while (counted < PHASE_BLOCKS) begin
                if ($urandom_range(0, 9) == 0) begin
                    bx = $urandom_range(0, 4095);
                    by = $urandom_range(0, 4095);
                end else begin
                    bx = $urandom_range(0, (w_eff - 1) / 4);
                    by = $urandom_range(0, (h_eff - 1) / 4);
                end
                if (bx * 4 < w_eff && by * 4 < h_eff)
                    counted++;
                send_block(12'(bx), 12'(by), rand_color(), rand_alpha());
            end
            settle();
        end

        if (sb.errors == 0 && sb.texel_q.size() == 0) begin
            $display("PASS bc1_bc3_block_decoder");
        end else begin
            $display("FAIL bc1_bc3_block_decoder");
        end
        $finish;
    end
endmodule
